### src/dfsa_pkg.sv
// package: shared types and constants for the deadline-first supply allocator
`timescale 1ns / 1ps
package dfsa_pkg;
  localparam int HeapDepth = 1024;
  localparam int AddrBits = $clog2(HeapDepth);
  localparam int CountBits = AddrBits + 1;
  localparam int PosBits = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SUPPLY = 2'd1,
    KIND_DEMAND = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] deadline;
    logic [30:0] supply_capacity;
    logic [30:0] demand_amount;
  } req_t;

  typedef struct packed {
    logic [30:0] shortfall;
    logic position_covered;
    logic all_covered;
    logic heap_overflowed;
    logic [15:0] position_index;
  } res_t;

  typedef struct packed {
    logic [15:0] dl;
    logic [30:0] cap;
  } entry_t;

  // heap order: smaller deadline first, then larger capacity
  function automatic logic ahead(entry_t a, entry_t b);
    if (a.dl != b.dl) return a.dl < b.dl;
    return a.cap > b.cap;
  endfunction
endpackage

### src/deadline_first_supply_allocator.sv
// top level: heap-based earliest-deadline-first allocator
// a supplier holds busy while it rises through the heap (S_UP, S_UP_CMP per level)
// a demand holds busy through root reads, root checks, pops and sift-down steps, then
//   S_FINISH; done is registered there and is high as busy falls
// requests: one at a time; clear, unused kind or dropped supplier never raise busy
// reset: synchronous, clears count, position and flags; heap contents undefined
`timescale 1ns / 1ps
module deadline_first_supply_allocator (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dfsa_pkg::req_t  request,
  output logic            busy,
  output logic            done,
  output dfsa_pkg::res_t  result
);
  localparam int AB = dfsa_pkg::AddrBits;
  localparam int CB = dfsa_pkg::CountBits;
  localparam int PB = dfsa_pkg::PosBits;

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_UP_CMP, S_ROOT_RD, S_ROOT_CHK, S_POP, S_POP_LD,
    S_DN_L, S_DN_R, S_DN_CMP, S_FINISH
  } state_t;

  state_t state;
  logic [CB-1:0] count;
  logic [PB-1:0] pos;
  logic all_ok, ovf;
  logic [30:0] rem;
  logic [AB-1:0] idx;
  dfsa_pkg::entry_t cur, lch;
  logic left_best;   // left child beats the hole value
  logic stop_after;  // demand ends once this heap step is done

  logic we;
  logic [AB-1:0] waddr, raddr;
  dfsa_pkg::entry_t wdata, rdata;

  dfsa_ram #(.Depth(dfsa_pkg::HeapDepth), .Width($bits(dfsa_pkg::entry_t))) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // child and parent indexes; child indexes widened to detect end of heap
  logic [CB:0] lidx, ridx, count_x;
  logic [AB-1:0] pidx;
  logic r_valid;
  assign lidx = {1'b0, idx, 1'b1};
  assign ridx = lidx + (CB+1)'(1);
  assign count_x = {1'b0, count};
  assign pidx = (idx - AB'(1)) >> 1;
  assign r_valid = (ridx < count_x);

  // sift decisions
  logic up_move, right_best;
  dfsa_pkg::entry_t dn_pick;
  assign up_move = dfsa_pkg::ahead(cur, rdata);
  assign dn_pick = left_best ? lch : cur;
  assign right_best = r_valid && dfsa_pkg::ahead(rdata, dn_pick);

  assign busy = (state != S_IDLE);

  // heap memory access per state
  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = cur;
    raddr = '0;
    unique case (state)
      S_UP: begin
        if (idx == '0) we = 1'b1;
        else raddr = pidx;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_move) wdata = rdata;
      end
      S_POP: raddr = AB'(count - CB'(1));
      S_DN_L: begin
        if (lidx >= count_x) we = 1'b1;
        else raddr = AB'(lidx);
      end
      S_DN_R: raddr = AB'(ridx);
      S_DN_CMP: begin
        we = 1'b1;
        if (right_best) wdata = rdata;
        else if (left_best) wdata = lch;
      end
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pos <= '0;
      all_ok <= 1'b1;
      ovf <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (dfsa_pkg::kind_t'(request.kind))
              dfsa_pkg::KIND_CLEAR: begin
                count <= '0; pos <= '0; all_ok <= 1'b1; ovf <= 1'b0;
              end
              dfsa_pkg::KIND_SUPPLY: begin
                if (count == CB'(dfsa_pkg::HeapDepth)) ovf <= 1'b1;
                else begin
                  cur <= '{dl: request.deadline, cap: request.supply_capacity};
                  idx <= AB'(count);
                  count <= count + CB'(1);
                  state <= S_UP;
                end
              end
              dfsa_pkg::KIND_DEMAND: begin
                rem <= request.demand_amount;
                state <= S_ROOT_RD;
              end
              dfsa_pkg::KIND_UNUSED: ;
            endcase
          end
        end
        // sift up: hole at idx holds cur
        S_UP: state <= (idx == '0) ? S_IDLE : S_UP_CMP;
        S_UP_CMP: begin
          if (up_move) begin
            idx <= pidx;
            state <= S_UP;
          end else state <= S_IDLE;
        end
        // look at the top of the heap
        S_ROOT_RD: state <= (count == '0) ? S_FINISH : S_ROOT_CHK;
        S_ROOT_CHK: begin
          if (rdata.dl < pos) begin
            // expired supplier
            stop_after <= 1'b0;
            state <= S_POP;
          end else if (rdata.cap > rem) begin
            // covering supplier keeps its remainder at the root
            stop_after <= 1'b1;
            cur <= '{dl: rdata.dl, cap: rdata.cap - rem};
            idx <= '0;
            rem <= '0;
            state <= (rem == '0) ? S_FINISH : S_DN_L;
          end else begin
            // supplier used up
            stop_after <= (rdata.cap == rem);
            rem <= rem - rdata.cap;
            state <= S_POP;
          end
        end
        // pop: move last to root and sift down, unless the heap empties
        S_POP: begin
          count <= count - CB'(1);
          idx <= '0;
          if (count == CB'(1)) state <= stop_after ? S_FINISH : S_ROOT_RD;
          else state <= S_POP_LD;
        end
        S_POP_LD: begin
          cur <= rdata;
          state <= S_DN_L;
        end
        // sift down: hole at idx holds cur
        S_DN_L: begin
          if (lidx >= count_x) state <= stop_after ? S_FINISH : S_ROOT_RD;
          else state <= S_DN_R;
        end
        S_DN_R: begin
          lch <= rdata;
          left_best <= dfsa_pkg::ahead(rdata, cur);
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (right_best) begin
            idx <= AB'(ridx);
            state <= S_DN_L;
          end else if (left_best) begin
            idx <= AB'(lidx);
            state <= S_DN_L;
          end else state <= stop_after ? S_FINISH : S_ROOT_RD;
        end
        S_FINISH: begin
          done <= 1'b1;
          result.shortfall <= rem;
          result.position_covered <= (rem == '0);
          result.all_covered <= all_ok && (rem == '0);
          if (rem != '0) all_ok <= 1'b0;
          result.heap_overflowed <= ovf;
          result.position_index <= pos;
          pos <= pos + PB'(1);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### src/dfsa_ram.sv
// generic single-port-write, single-read synchronous ram
`timescale 1ns / 1ps
module dfsa_ram #(
  parameter int Depth = 1024,
  parameter int Width = 47
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

### src/dfsa_checker.sv
// checker: port-level properties of the allocator, bound to the top level
`timescale 1ns / 1ps
module dfsa_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input dfsa_pkg::req_t request,
  input logic           busy,
  input logic           done,
  input dfsa_pkg::res_t result
);
  // covered flag agrees with shortfall
  a_cov: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.position_covered == (result.shortfall == '0)))
    else $error("covered flag mismatch");
  // all-covered implies this position covered
  a_all: assert property (@(posedge clk) disable iff (rst)
    done && result.all_covered |-> result.position_covered)
    else $error("all_covered without coverage");
  // a result only ends a busy request
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without request");
  // idle after reset
  a_rst: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy after reset");
endmodule

bind deadline_first_supply_allocator dfsa_checker u_chk (.*);
